[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants of the FIFO page pool directory.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int POOL_DEPTH = 8;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int MISS_W     = 31;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [15:0]      table_id;
    logic [15:0]      page_number;
    logic             is_matrix;
    logic [MISS_W-1:0] count_value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [15:0]       evicted_table;
    logic [15:0]       evicted_page;
    logic [MISS_W-1:0] miss_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] occupancy;
  } dp_status_t;

endpackage

[hw/rtl/fifo_page_pool_directory.sv]
// ----------------------------------------------------------------------------
// fifo_page_pool_directory
// Tag directory of a page buffer pool with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries one operation per
//   beat: lookup, remove page, clear pool or load miss counter, keyed by
//   table_id and page_number. Response channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one beat per request, in request order: hit, eviction
//   report and the miss count after the operation.
//   An accepted request passes the controller sequence capture -> compare
//   all slots -> apply update and load the result; rsp_valid rises as the
//   result is loaded. A new request is taken only after the last is applied.
//   The compare of all POOL_DEPTH slots happens in parallel.
//   A finished result waits in the output register while the next request
//   is accepted; if the receiver stalls past that, the update step holds
//   and req_stall stays high until the output register drains.
//   Reset empties the pool and zeroes the miss counter; the key store itself
//   is not cleared, since only slots below the occupancy count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_page_pool_directory (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fpd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fpd_pkg::rsp_t rsp
);

  fpd_pkg::dp_cmd_t    cmd;
  fpd_pkg::dp_status_t status;

  // Sequencer: owns the handshakes and steps the datapath.
  fpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Datapath: key store, compare, counters and result register.
  fpd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .rsp    (rsp),
    .status (status)
  );

  // Occupancy never exceeds the pool depth.
  `ASSERT_ALWAYS(a_occ_bound, status.occupancy <= fpd_pkg::CNT_W'(fpd_pkg::POOL_DEPTH), "occupancy above pool depth")
  // An accepted request closes the input until it has been processed.
  `ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request accepted while busy")
  // A result never reports both a hit and an eviction.
  `ASSERT_ALWAYS(a_hit_no_evict, !(rsp_valid && rsp.hit && rsp.evicted), "hit and eviction together")
  // An eviction leaves the pool full.
  `ASSERT_ALWAYS(a_evict_full, !(rsp_valid && rsp.evicted) || (status.occupancy == fpd_pkg::CNT_W'(fpd_pkg::POOL_DEPTH)), "eviction without full pool")

endmodule

[hw/rtl/fpd_ctrl.sv]
// ----------------------------------------------------------------------------
// fpd_ctrl
// Sequencer: capture a request, compare it, apply it, and hand the result
// to the output register when that register is free.
// ----------------------------------------------------------------------------
module fpd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output fpd_pkg::dp_cmd_t cmd
);

  fpd_pkg::ctl_state_t state;
  fpd_pkg::ctl_state_t state_next;
  logic                rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpd_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    req_stall   = 1'b1;
    case (state)
      fpd_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = fpd_pkg::ST_MATCH;
        end
      end
      fpd_pkg::ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = fpd_pkg::ST_UPDATE;
      end
      fpd_pkg::ST_UPDATE: begin
        // hold until the output register is empty or draining
        if (!rsp_valid || !rsp_stall) begin
          cmd.update = 1'b1;
          state_next = fpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpd_pkg::ST_IDLE;
      end
    endcase
    rsp_valid_next = cmd.update | (rsp_valid & rsp_stall);
  end

endmodule

[hw/rtl/fpd_datapath.sv]
// ----------------------------------------------------------------------------
// fpd_datapath
// Key store in arrival order, parallel tag compare, occupancy and miss
// counter, and the result register.
// ----------------------------------------------------------------------------
module fpd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  fpd_pkg::req_t      req,
  input  fpd_pkg::dp_cmd_t   cmd,
  output fpd_pkg::rsp_t      rsp,
  output fpd_pkg::dp_status_t status
);

  fpd_pkg::req_t                req_q;
  logic [31:0]                  keys      [fpd_pkg::POOL_DEPTH];
  logic [31:0]                  keys_next [fpd_pkg::POOL_DEPTH];
  logic [fpd_pkg::CNT_W-1:0]    occupancy;
  logic [fpd_pkg::CNT_W-1:0]    occupancy_next;
  logic [fpd_pkg::MISS_W-1:0]   miss_counter;
  logic [fpd_pkg::MISS_W-1:0]   miss_counter_next;
  logic [31:0]                  key_q;
  logic                         hit_c;
  logic [fpd_pkg::IDX_W-1:0]    pos_c;
  logic                         hit_q;
  logic [fpd_pkg::IDX_W-1:0]    pos_q;
  fpd_pkg::rsp_t                rsp_next;

  assign key_q            = {req_q.table_id, req_q.page_number};
  assign status.occupancy = occupancy;

  // Compare against every resident slot; keep the oldest match.
  always_comb begin
    hit_c = 1'b0;
    pos_c = '0;
    for (int i = fpd_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
      if ((fpd_pkg::CNT_W'(i) < occupancy) && (keys[i] == key_q)) begin
        hit_c = 1'b1;
        pos_c = fpd_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    keys_next         = keys;
    occupancy_next    = occupancy;
    miss_counter_next = miss_counter;
    rsp_next          = '0;
    case (req_q.op)
      fpd_pkg::OP_LOOKUP: begin
        if (hit_q) begin
          rsp_next.hit = 1'b1;
        end else begin
          if (occupancy == fpd_pkg::CNT_W'(fpd_pkg::POOL_DEPTH)) begin
            // full: drop the oldest, advance the rest, append at the young end
            rsp_next.evicted       = 1'b1;
            rsp_next.evicted_table = keys[0][31:16];
            rsp_next.evicted_page  = keys[0][15:0];
            for (int i = 0; i < fpd_pkg::POOL_DEPTH - 1; i++) begin
              keys_next[i] = keys[i+1];
            end
            keys_next[fpd_pkg::POOL_DEPTH-1] = key_q;
          end else begin
            for (int i = 0; i < fpd_pkg::POOL_DEPTH; i++) begin
              if (fpd_pkg::CNT_W'(i) == occupancy) begin
                keys_next[i] = key_q;
              end
            end
            occupancy_next = occupancy + fpd_pkg::CNT_W'(1);
          end
          if (req_q.is_matrix && (miss_counter != fpd_pkg::MISS_MAX)) begin
            miss_counter_next = miss_counter + fpd_pkg::MISS_W'(1);
          end
        end
      end
      fpd_pkg::OP_REMOVE: begin
        if (hit_q) begin
          rsp_next.hit = 1'b1;
          // close the gap toward the old end
          for (int i = 0; i < fpd_pkg::POOL_DEPTH - 1; i++) begin
            if (fpd_pkg::IDX_W'(i) >= pos_q) begin
              keys_next[i] = keys[i+1];
            end
          end
          occupancy_next = occupancy - fpd_pkg::CNT_W'(1);
        end
      end
      fpd_pkg::OP_CLEAR: begin
        occupancy_next = '0;
      end
      fpd_pkg::OP_LOAD: begin
        miss_counter_next = req_q.count_value;
      end
      default: begin
      end
    endcase
    rsp_next.miss_count = miss_counter_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.match) begin
      hit_q <= hit_c;
      pos_q <= pos_c;
    end
    if (cmd.update) begin
      keys <= keys_next;
      rsp  <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy    <= '0;
      miss_counter <= '0;
    end else if (cmd.update) begin
      occupancy    <= occupancy_next;
      miss_counter <= miss_counter_next;
    end
  end

endmodule

[dv/tb_fifo_page_pool_directory.sv]
// ----------------------------------------------------------------------------
// tb_fifo_page_pool_directory
// Self-checking bench for the FIFO page pool directory.
// ----------------------------------------------------------------------------
// A directed opening covers the extremes of the key fields, every operation,
// counter saturation, eviction, removal with gap closing and clearing. About
// 1100 random operations follow. They mostly use a small key space, so that
// hits, evictions and removals of resident pages come up often. Every
// accepted request beat is run through a directory model held in the bench.
// Each response beat is compared field by field with the oldest prediction.
// Both channels idle at random, apart from one stretch of back-to-back
// traffic.
// ----------------------------------------------------------------------------
module tb_fifo_page_pool_directory;

  localparam int NUM_RANDOM   = 1100;
  localparam int IDLE_PCT     = 29;
  // Beats in this window run with neither side idling.
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 650;
  localparam int DRAIN_CYCLES = 10;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  fpd_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  fpd_pkg::rsp_t rsp;

  // Request beats waiting to be driven, and responses owed by the block.
  fpd_pkg::req_t req_backlog[$];
  fpd_pkg::rsp_t rsp_due[$];

  // Directory model: keys in arrival order, slot 0 holds the oldest page.
  logic [31:0]                pool_keys[fpd_pkg::POOL_DEPTH];
  int                         pool_fill  = 0;
  logic [fpd_pkg::MISS_W-1:0] miss_total = '0;

  logic req_fired   = 1'b0;
  int   beats_taken = 0;
  int   fail_count  = 0;

  fifo_page_pool_directory i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop the slot at pos and close the gap toward the old end.
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < pool_fill; i++) begin
      pool_keys[i] = pool_keys[i + 1];
    end
    pool_fill--;
  endfunction

  // Apply one operation to the directory model and return the response.
  function automatic fpd_pkg::rsp_t apply_to_directory(fpd_pkg::req_t r);
    fpd_pkg::rsp_t o;
    logic [31:0]   key;
    int            pos;
    o   = '0;
    key = {r.table_id, r.page_number};
    pos = -1;
    for (int i = pool_fill - 1; i >= 0; i--) begin
      if (pool_keys[i] == key) begin
        pos = i;
      end
    end
    case (r.op)
      fpd_pkg::OP_LOOKUP: begin
        if (pos >= 0) begin
          o.hit = 1'b1;
        end else begin
          if (pool_fill == fpd_pkg::POOL_DEPTH) begin
            o.evicted       = 1'b1;
            o.evicted_table = pool_keys[0][31:16];
            o.evicted_page  = pool_keys[0][15:0];
            drop_slot(0);
          end
          pool_keys[pool_fill] = key;
          pool_fill++;
          // Count only matrix misses, and hold at the top.
          if (r.is_matrix && miss_total != fpd_pkg::MISS_MAX) begin
            miss_total++;
          end
        end
      end
      fpd_pkg::OP_REMOVE: begin
        if (pos >= 0) begin
          o.hit = 1'b1;
          drop_slot(pos);
        end
      end
      fpd_pkg::OP_CLEAR: begin
        pool_fill = 0;
      end
      default: begin
        miss_total = r.count_value;
      end
    endcase
    o.miss_count = miss_total;
    return o;
  endfunction

  function automatic fpd_pkg::req_t make_beat(fpd_pkg::op_t op, logic [15:0] tbl,
                                              logic [15:0] pg, logic mtx,
                                              logic [fpd_pkg::MISS_W-1:0] cval);
    fpd_pkg::req_t r;
    r.op          = op;
    r.table_id    = tbl;
    r.page_number = pg;
    r.is_matrix   = mtx;
    r.count_value = cval;
    return r;
  endfunction

  // Append one beat at the tail of the pending list.
  function automatic void enqueue(fpd_pkg::req_t r);
    req_backlog = {req_backlog, r};
  endfunction

  function automatic bit side_idles();
    if (beats_taken >= CALM_FIRST && beats_taken < CALM_LAST) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on accepted request beats, then check accepted response beats.
  always @(posedge clk) begin
    fpd_pkg::rsp_t want;
    fpd_pkg::rsp_t owed;
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        owed    = apply_to_directory(req);
        rsp_due = {rsp_due, owed};
        beats_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          $error("response beat with no request outstanding");
          fail_count++;
        end else begin
          want = rsp_due[0];
          rsp_due.delete(0);
          flag_field("hit", 32'(want.hit), 32'(rsp.hit));
          flag_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
          flag_field("evicted_table", 32'(want.evicted_table), 32'(rsp.evicted_table));
          flag_field("evicted_page", 32'(want.evicted_page), 32'(rsp.evicted_page));
          flag_field("miss_count", 32'(want.miss_count), 32'(rsp.miss_count));
        end
      end
    end
  end

  // Request driver: hold a beat until it is taken, then advance or idle.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fired) begin
      if (req_backlog.size() != 0 && !side_idles()) begin
        req_valid <= 1'b1;
        req       <= req_backlog[0];
        req_backlog.delete(0);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: stall at random.
  always @(negedge clk) begin
    rsp_stall <= !rst && side_idles();
  end

  initial begin
    int                         roll;
    fpd_pkg::op_t               op;
    logic [15:0]                tbl;
    logic [15:0]                pg;
    logic [fpd_pkg::MISS_W-1:0] cval;

    // Directed opening: saturate the counter, fill the pool, evict, remove.
    enqueue(make_beat(fpd_pkg::OP_LOAD, 16'h0000, 16'h0000, 1'b0,
                      fpd_pkg::MISS_MAX - fpd_pkg::MISS_W'(1)));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 1'b1, fpd_pkg::MISS_MAX));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'hffff, 16'h0000, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0000, 16'hffff, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOAD, 16'hffff, 16'hffff, 1'b1, '0));
    for (int i = 1; i <= 4; i++) begin
      enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0001, 16'(i), 1'b1, '0));
    end
    // Pool is full here; this miss pushes out the oldest page.
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0002, 16'h0000, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_REMOVE, 16'h0001, 16'h0002, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_REMOVE, 16'h0001, 16'h0002, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0003, 16'h0003, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0004, 16'h0004, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_CLEAR, 16'hffff, 16'hffff, 1'b1, fpd_pkg::MISS_MAX));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'hffff, 16'hffff, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_REMOVE, 16'hffff, 16'hffff, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_REMOVE, 16'hffff, 16'hffff, 1'b0, '0));
    enqueue(make_beat(fpd_pkg::OP_LOAD, 16'h0000, 16'h0000, 1'b0, fpd_pkg::MISS_MAX));
    enqueue(make_beat(fpd_pkg::OP_LOOKUP, 16'h0005, 16'h0005, 1'b1, '0));
    enqueue(make_beat(fpd_pkg::OP_LOAD, 16'h0000, 16'h0000, 1'b0, '0));

    // Random part: a small key space keeps hits and removals frequent.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        op = fpd_pkg::OP_LOOKUP;
      end else if (roll < 87) begin
        op = fpd_pkg::OP_REMOVE;
      end else if (roll < 91) begin
        op = fpd_pkg::OP_CLEAR;
      end else begin
        op = fpd_pkg::OP_LOAD;
      end
      tbl  = ($urandom_range(9) < 8) ? 16'($urandom_range(3)) : 16'($urandom);
      pg   = ($urandom_range(9) < 8) ? 16'($urandom_range(11)) : 16'($urandom);
      cval = fpd_pkg::MISS_W'($urandom);
      // Park some loads near the top so that matrix misses saturate.
      if (op == fpd_pkg::OP_LOAD) begin
        case ($urandom_range(2))
          0: cval = fpd_pkg::MISS_MAX - fpd_pkg::MISS_W'($urandom_range(3));
          1: cval = fpd_pkg::MISS_W'($urandom_range(15));
          default: ;
        endcase
      end
      enqueue(make_beat(op, tbl, pg, 1'($urandom_range(1)), cval));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[fifo_page_pool_directory.f]
+incdir+hw/rtl
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_ctrl.sv
hw/rtl/fpd_datapath.sv
hw/rtl/fifo_page_pool_directory.sv
dv/tb_fifo_page_pool_directory.sv
